// ----- hdl/parabolic_stop_and_reverse_macros.svh -----
// assertion helpers for the parabolic stop-and-reverse block
`ifndef PARABOLIC_STOP_AND_REVERSE_MACROS_SVH
`define PARABOLIC_STOP_AND_REVERSE_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define PSAR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("psar check failed");
// property checked on every clock edge, reset included
`define PSAR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("psar check failed");
`else
`define PSAR_ASSERT(label, clk, rst_n, prop)
`define PSAR_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- hdl/psar_pkg.sv -----
package psar_pkg;

    // field widths
    localparam int PRICE_W    = 24;
    localparam int FRAC_W     = 16;
    localparam int STOP_W     = PRICE_W + FRAC_W;
    localparam int ACCEL_W    = 16;
    localparam int WIN_W      = 4;
    localparam int CNT_W      = 5;
    localparam int OUT_W      = 25;
    localparam int TREND_W    = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int S_DATA_W   = 4 * PRICE_W;
    localparam int M_DATA_W   = 32;

    // storage depth of the extreme window
    localparam int WINDOW_DEPTH_DEF = 16;

    // register reset values
    localparam logic [WIN_W-1:0]   WINDOW_BARS_RST = 4'd4;
    localparam logic [ACCEL_W-1:0] ACCEL_START_RST = 16'd1311;
    localparam logic [ACCEL_W-1:0] ACCEL_STEP_RST  = 16'd1311;
    localparam logic [ACCEL_W-1:0] ACCEL_LIMIT_RST = 16'd13107;

    // bar count never goes above the widest window plus two
    localparam logic [CNT_W-1:0] BAR_COUNT_MAX = 5'd17;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BARS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT = 2'd3;

    // half a cent in the Q16 stop format
    localparam logic [FRAC_W:0] ROUND_HALF = 17'h08000;

    typedef enum logic [TREND_W-1:0] {
        TREND_WARM     = 3'd0,
        TREND_RISE     = 3'd1,
        TREND_FALL     = 3'd2,
        TREND_RISE_REV = 3'd3,
        TREND_FALL_REV = 3'd4
    } trend_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_CALC = 1'b1
    } state_t;

endpackage

// ----- hdl/parabolic_stop_and_reverse.sv -----
// Parabolic stop-and-reverse over a stream of price bars.
// Input channel s_*: one bar per item, s_tdata holds open, high, low and
// close in cents, s_tuser flags the first bar of a new series.
// Output channel m_*: one item per bar, the stop level rounded half up to
// cents (-1 during warm-up) and the trend code.
// Configuration: cfg_wr_en, cfg_index and cfg_data write one register per
// cycle; write only while no bar is in flight.
// Timing: a bar accepted at one edge is computed in the following cycle and
// its result is registered onto m_tvalid when that update completes. The
// accept cycle feeds the cell row and the 16x41 stop multiplier, the update
// cycle adds, rounds and updates the trend. No new bar is taken until the
// update of the last one is done.
// A result waiting on m_tready does not block the next bar from being
// accepted; that bar then holds in its update cycle until the output frees.
// Reset: registers go to their defaults, the series state clears and the
// first bar after reset starts a new series. No clearing pass is needed,
// the cell row is only read over bars of the running series.
`include "parabolic_stop_and_reverse_macros.svh"
module parabolic_stop_and_reverse #(
    parameter int WINDOW_DEPTH = psar_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [psar_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psar_pkg::CFG_DATA_W-1:0]   cfg_data,
    // bar input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // open_price, high_price, low_price, close_price
    input  logic [psar_pkg::S_DATA_W-1:0]     s_tdata,
    // series_start
    input  logic                              s_tuser,
    // result output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // stop_value, trend_state, zero fill
    output logic [psar_pkg::M_DATA_W-1:0]     m_tdata
);
    import psar_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int SPAN_W = ($clog2(WINDOW_DEPTH + 1) > CNT_W + 1) ?
                            $clog2(WINDOW_DEPTH + 1) : CNT_W + 1;
    localparam int DIFF_W = STOP_W + 1;
    localparam int PROD_W = DIFF_W + ACCEL_W + 1;
    localparam int RND_W  = PROD_W + 1 - FRAC_W;
    localparam int SUM_W  = RND_W + 1;

    // configuration registers
    logic [WIN_W-1:0]   window_bars_reg;
    logic [ACCEL_W-1:0] accel_start_reg;
    logic [ACCEL_W-1:0] accel_step_reg;
    logic [ACCEL_W-1:0] accel_limit_reg;

    // series state
    logic [PRICE_W-1:0] first_open_reg, first_open_next;
    logic [CNT_W-1:0]   bar_count_reg, bar_count_next;
    trend_t             trend_reg, trend_next;
    logic [ACCEL_W-1:0] accel_reg, accel_next;
    logic [STOP_W-1:0]  stop_reg, stop_next;
    logic [PRICE_W-1:0] win_high_reg, win_high_next;
    logic [PRICE_W-1:0] win_low_reg, win_low_next;

    // captured bar
    logic               start_reg;
    logic [PRICE_W-1:0] open_reg, high_reg, low_reg, close_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    // control
    state_t state_reg, state_next;
    logic   accept, calc_done;

    // output register
    logic               m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]   m_stop_reg, m_stop_next;
    logic [TREND_W-1:0] m_trend_reg, m_trend_next;

    // cell row outputs
    logic [PRICE_W-1:0] chain_high, chain_low;
    logic [IDX_W-1:0]   span_idx;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_bars_reg <= WINDOW_BARS_RST;
            accel_start_reg <= ACCEL_START_RST;
            accel_step_reg  <= ACCEL_STEP_RST;
            accel_limit_reg <= ACCEL_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WINDOW_BARS: window_bars_reg <= cfg_data[WIN_W-1:0];
                REG_ACCEL_START: accel_start_reg <= cfg_data[ACCEL_W-1:0];
                REG_ACCEL_STEP:  accel_step_reg  <= cfg_data[ACCEL_W-1:0];
                REG_ACCEL_LIMIT: accel_limit_reg <= cfg_data[ACCEL_W-1:0];
                default: ;
            endcase
        end
    end

    // state machine: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_CALC;
            ST_CALC: if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // state machine: outputs
    always_comb begin
        s_tready  = 1'b0;
        calc_done = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready  = 1'b1;
            ST_CALC: calc_done = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // stop pull product, toward the high on a rising trend, else the low
    always_comb begin
        logic [PRICE_W-1:0]       ext;
        logic signed [DIFF_W-1:0] diff;
        ext       = (trend_reg == TREND_RISE) ? win_high_reg : win_low_reg;
        diff      = $signed({1'b0, ext, {FRAC_W{1'b0}}}) - $signed({1'b0, stop_reg});
        prod_next = PROD_W'($signed({1'b0, accel_reg}) * diff);
    end

    // capture the bar
    always_ff @(posedge aclk) begin
        if (accept) begin
            start_reg <= s_tuser;
            open_reg  <= s_tdata[PRICE_W-1:0];
            high_reg  <= s_tdata[2*PRICE_W-1:PRICE_W];
            low_reg   <= s_tdata[3*PRICE_W-1:2*PRICE_W];
            close_reg <= s_tdata[4*PRICE_W-1:3*PRICE_W];
            prod_reg  <= prod_next;
        end
    end

    // row of cells keeping the running extremes
    psar_chain #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_chain (
        .aclk     (aclk),
        .shift_en (accept),
        .bar_high (s_tdata[2*PRICE_W-1:PRICE_W]),
        .bar_low  (s_tdata[3*PRICE_W-1:2*PRICE_W]),
        .span_idx (span_idx),
        .win_high (chain_high),
        .win_low  (chain_low)
    );

    // series update for the captured bar
    always_comb begin
        logic                    restart;
        logic [CNT_W-1:0]        bc;
        logic [PRICE_W-1:0]      fo, wh, wl;
        trend_t                  tr;
        logic [ACCEL_W-1:0]      ac;
        logic [STOP_W-1:0]       sl;
        logic [CNT_W:0]          cnt, w0, w1, w2;
        logic [SPAN_W-1:0]       span;
        logic                    warm;
        logic signed [RND_W-1:0] rnd;
        logic signed [SUM_W-1:0] pulled;
        logic [STOP_W-1:0]       pulled_stop;
        logic [ACCEL_W:0]        bumped;
        logic [ACCEL_W-1:0]      bumped_accel;
        logic [STOP_W:0]         out_sum;

        restart = start_reg || (bar_count_reg == '0);
        bc = restart ? '0 : bar_count_reg;
        fo = restart ? open_reg : first_open_reg;
        wh = restart ? high_reg : win_high_reg;
        wl = restart ? low_reg : win_low_reg;
        tr = restart ? TREND_WARM : trend_reg;
        ac = restart ? accel_start_reg : accel_reg;
        sl = restart ? '0 : stop_reg;

        cnt = {1'b0, bc} + 1'b1;
        w0  = (CNT_W + 1)'(window_bars_reg);
        w1  = w0 + 1'b1;
        w2  = w0 + 2'd2;

        // pulled stop, product rounded half up to Q16 and floored at zero
        rnd    = RND_W'((prod_reg + $signed({1'b0, ROUND_HALF})) >>> FRAC_W);
        pulled = $signed({{(SUM_W - STOP_W){1'b0}}, sl}) + SUM_W'(rnd);
        pulled_stop = pulled[SUM_W-1] ? '0 : pulled[STOP_W-1:0];

        // accel step with cap
        bumped = {1'b0, ac} + {1'b0, accel_step_reg};
        bumped_accel = (bumped > {1'b0, accel_limit_reg}) ?
                       accel_limit_reg : bumped[ACCEL_W-1:0];

        warm       = 1'b0;
        trend_next = tr;
        stop_next  = sl;
        accel_next = ac;

        if (cnt <= w0) begin
            warm = 1'b1;
        end else if (cnt == w1) begin
            // first bar after warm-up picks the direction
            if (close_reg > fo) begin
                trend_next = (low_reg <= wl) ? TREND_RISE_REV : TREND_RISE;
                stop_next  = {wl, {FRAC_W{1'b0}}};
            end else begin
                trend_next = (high_reg >= wh) ? TREND_FALL_REV : TREND_FALL;
                stop_next  = {wh, {FRAC_W{1'b0}}};
            end
        end else begin
            case (tr)
                TREND_RISE: begin
                    stop_next = pulled_stop;
                    if (high_reg > wh) accel_next = bumped_accel;
                    if ({low_reg, {FRAC_W{1'b0}}} <= pulled_stop) begin
                        trend_next = TREND_RISE_REV;
                    end
                end
                TREND_FALL: begin
                    stop_next = pulled_stop;
                    if (low_reg < wl) accel_next = bumped_accel;
                    if ({high_reg, {FRAC_W{1'b0}}} >= pulled_stop) begin
                        trend_next = TREND_FALL_REV;
                    end
                end
                TREND_RISE_REV: begin
                    stop_next  = {wh, {FRAC_W{1'b0}}};
                    accel_next = accel_start_reg;
                    trend_next = TREND_FALL;
                end
                TREND_FALL_REV: begin
                    stop_next  = {wl, {FRAC_W{1'b0}}};
                    accel_next = accel_start_reg;
                    trend_next = TREND_RISE;
                end
                default: ;
            endcase
        end

        first_open_next = fo;
        bar_count_next  = ({1'b0, bc} < w2) ? cnt[CNT_W-1:0] : bc;

        // extremes over the span ending at this bar
        span = SPAN_W'(cnt);
        if (span > SPAN_W'(w1)) span = SPAN_W'(w1);
        if (span > SPAN_W'(WINDOW_DEPTH)) span = SPAN_W'(WINDOW_DEPTH);
        span_idx      = IDX_W'(span - 1'b1);
        win_high_next = chain_high;
        win_low_next  = chain_low;

        // result item
        out_sum = {1'b0, stop_next} + (STOP_W + 1)'(ROUND_HALF);
        if (warm) begin
            m_stop_next  = '1;
            m_trend_next = TREND_WARM;
        end else begin
            m_stop_next  = out_sum[STOP_W:FRAC_W];
            m_trend_next = trend_next;
        end
    end

    assign m_tvalid_next = calc_done || (m_tvalid_reg && !m_tready);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            bar_count_reg <= '0;
            trend_reg     <= TREND_WARM;
            accel_reg     <= ACCEL_START_RST;
            stop_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (calc_done) begin
                bar_count_reg <= bar_count_next;
                trend_reg     <= trend_next;
                accel_reg     <= accel_next;
                stop_reg      <= stop_next;
            end
        end
    end

    // series payload and result registers
    always_ff @(posedge aclk) begin
        if (calc_done) begin
            first_open_reg <= first_open_next;
            win_high_reg   <= win_high_next;
            win_low_reg    <= win_low_next;
            m_stop_reg     <= m_stop_next;
            m_trend_reg    <= m_trend_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - OUT_W - TREND_W){1'b0}}, m_trend_reg, m_stop_reg};

    // an accepted bar always goes on to its update cycle
    `PSAR_ASSERT(a_accept_to_calc, aclk, aresetn, accept |=> (state_reg == ST_CALC))
    // a warm-up stop always carries the warm-up trend code
    `PSAR_ASSERT(a_warm_code, aclk, aresetn,
        (m_tvalid && (m_tdata[OUT_W-1:0] == '1)) |-> (m_tdata[OUT_W+TREND_W-1:OUT_W] == '0))
    // bar count stays within the saturation bound
    `PSAR_ASSERT_ALWAYS(a_count_bound, aclk, !aresetn || (bar_count_reg <= BAR_COUNT_MAX))

endmodule

// ----- hdl/psar_cell.sv -----
module psar_cell (
    input  logic                          aclk,
    input  logic                          shift_en,
    input  logic [psar_pkg::PRICE_W-1:0]  bar_high,
    input  logic [psar_pkg::PRICE_W-1:0]  bar_low,
    input  logic [psar_pkg::PRICE_W-1:0]  prev_high,
    input  logic [psar_pkg::PRICE_W-1:0]  prev_low,
    output logic [psar_pkg::PRICE_W-1:0]  run_high,
    output logic [psar_pkg::PRICE_W-1:0]  run_low
);
    import psar_pkg::*;

    logic [PRICE_W-1:0] run_high_reg, run_high_next;
    logic [PRICE_W-1:0] run_low_reg,  run_low_next;

    // extremes of the new bar and the neighbor's span, one bar shorter
    always_comb begin
        run_high_next = (bar_high > prev_high) ? bar_high : prev_high;
        run_low_next  = (bar_low < prev_low) ? bar_low : prev_low;
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            run_high_reg <= run_high_next;
            run_low_reg  <= run_low_next;
        end
    end

    assign run_high = run_high_reg;
    assign run_low  = run_low_reg;

endmodule

// ----- hdl/psar_chain.sv -----
module psar_chain #(
    parameter int WINDOW_DEPTH = psar_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              shift_en,
    input  logic [psar_pkg::PRICE_W-1:0]      bar_high,
    input  logic [psar_pkg::PRICE_W-1:0]      bar_low,
    input  logic [$clog2(WINDOW_DEPTH)-1:0]   span_idx,
    output logic [psar_pkg::PRICE_W-1:0]      win_high,
    output logic [psar_pkg::PRICE_W-1:0]      win_low
);
    import psar_pkg::*;

    // cell k holds the extremes of the last k+1 bars
    logic [PRICE_W-1:0] run_high [WINDOW_DEPTH];
    logic [PRICE_W-1:0] run_low  [WINDOW_DEPTH];

    genvar k;
    generate
        for (k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
            if (k == 0) begin : g_head
                psar_cell u_cell (
                    .aclk      (aclk),
                    .shift_en  (shift_en),
                    .bar_high  (bar_high),
                    .bar_low   (bar_low),
                    .prev_high (bar_high),
                    .prev_low  (bar_low),
                    .run_high  (run_high[k]),
                    .run_low   (run_low[k])
                );
            end else begin : g_body
                psar_cell u_cell (
                    .aclk      (aclk),
                    .shift_en  (shift_en),
                    .bar_high  (bar_high),
                    .bar_low   (bar_low),
                    .prev_high (run_high[k-1]),
                    .prev_low  (run_low[k-1]),
                    .run_high  (run_high[k]),
                    .run_low   (run_low[k])
                );
            end
        end
    endgenerate

    // pick the cell that covers the current span
    assign win_high = run_high[span_idx];
    assign win_low  = run_low[span_idx];

endmodule
